@@ rtl/twsr_pkg.sv @@
package twsr_pkg;

  // Width of the shift register; older bits fall off the top
  localparam int unsigned WordBits = 32;
  localparam int unsigned OutBits  = 32;
  localparam logic [WordBits-1:0] InvertMask = WordBits'(64'h0080_0000);

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgBitCount    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgExtraPulses = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgHalfPeriod  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgIdleClock   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgReadyLevel  = 3'd4;

  // Stream widths
  localparam int unsigned InFieldBits = 2;
  localparam int unsigned InTdataW    = ((InFieldBits + 7) / 8) * 8;
  localparam int unsigned ResBits     = 3 + OutBits;
  localparam int unsigned OutTdataW   = ((ResBits + 7) / 8) * 8;

  typedef struct packed {
    logic [5:0]  bit_count;
    logic [3:0]  extra_pulses;
    logic [15:0] half_period;
    logic        idle_clock_level;
    logic        ready_level;
  } cfg_t;

  typedef struct packed {
    logic [OutBits-1:0] sample_word;
    logic               done_res;
    logic               busy_res;
    logic               clock_out;
  } res_t;

endpackage

@@ rtl/twsr_cfg.sv @@
module twsr_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [twsr_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [twsr_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output twsr_pkg::cfg_t                   cfg_o
);

  twsr_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_count        <= 6'd24;
      cfg_q.extra_pulses     <= 4'd1;
      cfg_q.half_period      <= 16'd1;
      cfg_q.idle_clock_level <= 1'b0;
      cfg_q.ready_level      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        twsr_pkg::CfgBitCount:    cfg_q.bit_count        <= cfg_wdata_i[5:0];
        twsr_pkg::CfgExtraPulses: cfg_q.extra_pulses     <= cfg_wdata_i[3:0];
        twsr_pkg::CfgHalfPeriod:  cfg_q.half_period      <= cfg_wdata_i[15:0];
        twsr_pkg::CfgIdleClock:   cfg_q.idle_clock_level <= cfg_wdata_i[0];
        twsr_pkg::CfgReadyLevel:  cfg_q.ready_level      <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/twsr_ctrl.sv @@
module twsr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic           start_i,
  input  logic           din_i,
  input  twsr_pkg::cfg_t cfg_i,
  output twsr_pkg::res_t res_o
);

  localparam logic [2:0] PhIdle  = 3'd0;
  localparam logic [2:0] PhWait  = 3'd1;
  localparam logic [2:0] PhHigh  = 3'd2;
  localparam logic [2:0] PhLow   = 3'd3;
  localparam logic [2:0] PhXHigh = 3'd4;
  localparam logic [2:0] PhXLow  = 3'd5;

  logic [2:0]                        phase_q, phase_d;
  logic [twsr_pkg::WordBits-1:0]     shift_q, shift_d;
  logic [5:0]                        bits_q, bits_d;
  logic [3:0]                        pulses_q, pulses_d;
  logic [15:0]                       tick_q, tick_d;
  logic                              clk_lvl_q, clk_lvl_d;
  logic [16:0]                       tick_inc;
  logic [15:0]                       half_len;
  logic                              half_end;
  logic                              go_next;
  logic                              done;

  assign half_len = (cfg_i.half_period == 16'd0) ? 16'd1 : cfg_i.half_period;
  assign tick_inc = {1'b0, tick_q} + 17'd1;
  assign half_end = tick_inc >= {1'b0, half_len};

  always_comb begin
    phase_d   = phase_q;
    shift_d   = shift_q;
    bits_d    = bits_q;
    pulses_d  = pulses_q;
    tick_d    = tick_q;
    clk_lvl_d = clk_lvl_q;
    go_next   = 1'b0;
    done      = 1'b0;

    unique case (phase_q)
      PhIdle: begin
        if (start_i) begin
          clk_lvl_d = cfg_i.idle_clock_level;
          phase_d   = PhWait;
        end
      end
      // ready is not looked at on the tick that takes the start
      PhWait: begin
        if (din_i == cfg_i.ready_level) begin
          shift_d  = '0;
          bits_d   = '0;
          pulses_d = '0;
          go_next  = 1'b1;
        end
      end
      PhHigh, PhXHigh: begin
        tick_d = tick_inc[15:0];
        if (half_end) begin
          if (phase_q == PhHigh) begin
            shift_d = {shift_q[twsr_pkg::WordBits-2:0], din_i};
            phase_d = PhLow;
          end else begin
            phase_d = PhXLow;
          end
          clk_lvl_d = 1'b0;
          tick_d    = '0;
        end
      end
      PhLow, PhXLow: begin
        tick_d = tick_inc[15:0];
        if (half_end) begin
          if (phase_q == PhLow) begin
            bits_d = bits_q + 6'd1;
          end else begin
            pulses_d = pulses_q + 4'd1;
          end
          go_next = 1'b1;
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase

    // pick the next pulse from the updated counts, or finish
    if (go_next) begin
      tick_d = '0;
      priority if (bits_d < cfg_i.bit_count) begin
        phase_d   = PhHigh;
        clk_lvl_d = 1'b1;
      end else if (pulses_d < cfg_i.extra_pulses) begin
        phase_d   = PhXHigh;
        clk_lvl_d = 1'b1;
      end else begin
        phase_d   = PhIdle;
        clk_lvl_d = 1'b0;
        done      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      shift_q   <= '0;
      bits_q    <= '0;
      pulses_q  <= '0;
      tick_q    <= '0;
      clk_lvl_q <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      shift_q   <= shift_d;
      bits_q    <= bits_d;
      pulses_q  <= pulses_d;
      tick_q    <= tick_d;
      clk_lvl_q <= clk_lvl_d;
    end
  end

  assign res_o.clock_out   = clk_lvl_d;
  assign res_o.busy_res    = phase_d != PhIdle;
  assign res_o.done_res    = done;
  assign res_o.sample_word = done ? twsr_pkg::OutBits'(shift_d ^ twsr_pkg::InvertMask)
                                  : '0;

endmodule

@@ rtl/two_wire_serial_sample_reader.sv @@
// Two-wire serial converter reader. Each input transaction is one timer tick
// carrying the start request and the sampled data pin; each tick returns
// exactly one output transaction with the clock pin level, busy, done and,
// on the done tick, the shifted-in word with bit 23 inverted (zero
// otherwise). The block takes one tick per clock cycle and answers on the next
// cycle: the read state registers update on every accepted tick and the
// result lands in an output register, so a stalled output only holds off the
// input while that register is full and not being taken. Configuration
// writes go through cfg_we_i/cfg_idx_i/cfg_wdata_i and belong to idle time.
module two_wire_serial_sample_reader (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [0] start_req, [1] data_in, rest zero
  input  logic [twsr_pkg::InTdataW-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] clock_out, [1] busy_res, [2] done_res, [34:3] sample_word, rest zero
  output logic [twsr_pkg::OutTdataW-1:0]    m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [twsr_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [twsr_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  twsr_pkg::cfg_t cfg;
  twsr_pkg::res_t res;
  twsr_pkg::res_t res_q;
  logic           out_valid_q;
  logic           accept;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  twsr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  twsr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (accept),
    .start_i (s_axis_tdata[0]),
    .din_i   (s_axis_tdata[1]),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(twsr_pkg::OutTdataW - twsr_pkg::ResBits){1'b0}}, res_q};

`ifndef SYNTHESIS
  // a finished read leaves the block idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.done_res) |-> !res_q.busy_res)
    else $error("done result reported while busy");

  // when idle the serial clock is parked low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !res_q.busy_res) |-> !res_q.clock_out)
    else $error("clock high while idle");

  // every accepted tick leaves a result in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("accepted tick produced no result");

  // a word only appears on the done tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !res_q.done_res) |-> (res_q.sample_word == '0))
    else $error("sample word nonzero outside done");
`endif

endmodule

@@ verif/tb_two_wire_serial_sample_reader.sv @@
module tb_two_wire_serial_sample_reader;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    RD_IDLE, RD_WAIT, RD_HIGH, RD_LOW, RD_XHIGH, RD_XLOW
  } reader_phase_e;

  // din above start, matching the input tdata packing
  typedef struct packed {
    logic din;
    logic start;
  } tick_t;

  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned SettleChunk    = 16;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 s_axis_tvalid = 1'b0;
  logic                                 s_axis_tready;
  logic [twsr_pkg::InTdataW-1:0]        s_axis_tdata = '0;
  logic                                 m_axis_tvalid;
  logic                                 m_axis_tready = 1'b0;
  logic [twsr_pkg::OutTdataW-1:0]       m_axis_tdata;
  logic                                 cfg_we_i = 1'b0;
  logic [twsr_pkg::CfgIdxW-1:0]         cfg_idx_i = '0;
  logic [twsr_pkg::CfgDataW-1:0]        cfg_wdata_i = '0;

  two_wire_serial_sample_reader dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Stimulus and scoreboard state
  tick_t            tick_q[$];
  twsr_pkg::res_t   predicted_beats_q[$];
  int unsigned      ticks_queued = 0;
  int unsigned      ticks_sent = 0;
  int unsigned      errors = 0;
  int unsigned      send_idle_pct = 18;
  int unsigned      recv_idle_pct = 82;
  int unsigned      hold_requests = 0;
  int unsigned      holds_served = 0;
  int unsigned      hold_left = 0;
  logic             in_fire = 1'b0;

  // Predicted reader state and register copy
  twsr_pkg::cfg_t                  cfg;
  reader_phase_e                   rd_phase;
  logic [twsr_pkg::WordBits-1:0]   rd_shift;
  int unsigned                     rd_bits, rd_pulses, rd_ticks;
  logic                            rd_clk;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Start the next data or extra pulse; returns 1 when the read is complete
  function automatic logic pick_next_pulse();
    rd_ticks = 0;
    if (rd_bits < cfg.bit_count) begin
      rd_phase = RD_HIGH;
      rd_clk = 1'b1;
      return 1'b0;
    end
    if (rd_pulses < cfg.extra_pulses) begin
      rd_phase = RD_XHIGH;
      rd_clk = 1'b1;
      return 1'b0;
    end
    rd_phase = RD_IDLE;
    rd_clk = 1'b0;
    return 1'b1;
  endfunction

  function automatic twsr_pkg::res_t step_reader(logic start, logic din);
    twsr_pkg::res_t r;
    logic           done;
    int unsigned    half;
    done = 1'b0;
    half = (cfg.half_period == 0) ? 1 : cfg.half_period;
    case (rd_phase)
      RD_IDLE: begin
        if (start) begin
          rd_clk = cfg.idle_clock_level;
          rd_phase = RD_WAIT;
        end
      end
      RD_WAIT: begin
        if (din == cfg.ready_level) begin
          rd_shift = '0;
          rd_bits = 0;
          rd_pulses = 0;
          done = pick_next_pulse();
        end
      end
      RD_HIGH, RD_XHIGH: begin
        rd_ticks++;
        if (rd_ticks >= half) begin
          if (rd_phase == RD_HIGH) begin
            rd_shift = {rd_shift[twsr_pkg::WordBits-2:0], din};
            rd_phase = RD_LOW;
          end else begin
            rd_phase = RD_XLOW;
          end
          rd_clk = 1'b0;
          rd_ticks = 0;
        end
      end
      RD_LOW, RD_XLOW: begin
        rd_ticks++;
        if (rd_ticks >= half) begin
          if (rd_phase == RD_LOW) rd_bits++;
          else rd_pulses++;
          done = pick_next_pulse();
        end
      end
      default: rd_phase = RD_IDLE;
    endcase
    r.clock_out = rd_clk;
    r.busy_res = (rd_phase != RD_IDLE);
    r.done_res = done;
    r.sample_word = done ? twsr_pkg::OutBits'(rd_shift ^ twsr_pkg::InvertMask) : '0;
    return r;
  endfunction

  task automatic note_mismatch(input string fld,
                               input logic [twsr_pkg::OutBits-1:0] want,
                               input logic [twsr_pkg::OutBits-1:0] got);
    $display("%0t: %s mismatch: expected %h, actual %h", $time, fld, want, got);
    errors++;
  endtask

  // Input driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata <= twsr_pkg::InTdataW'(tick_q.pop_front());
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output ready, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served < hold_requests) begin
      m_axis_tready <= 1'b0;
      hold_left <= LongHoldCycles;
      holds_served <= holds_served + 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on each input transaction, check each output transaction
  always @(posedge clk_i) begin
    twsr_pkg::res_t got;
    twsr_pkg::res_t want;
    if (rst_ni) begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_beats_q.push_back(step_reader(s_axis_tdata[0], s_axis_tdata[1]));
        ticks_sent++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = twsr_pkg::res_t'(m_axis_tdata[twsr_pkg::ResBits-1:0]);
        if (predicted_beats_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = predicted_beats_q.pop_front();
          if (got.clock_out !== want.clock_out)
            note_mismatch("clock_out", twsr_pkg::OutBits'(want.clock_out),
                          twsr_pkg::OutBits'(got.clock_out));
          if (got.busy_res !== want.busy_res)
            note_mismatch("busy_res", twsr_pkg::OutBits'(want.busy_res),
                          twsr_pkg::OutBits'(got.busy_res));
          if (got.done_res !== want.done_res)
            note_mismatch("done_res", twsr_pkg::OutBits'(want.done_res),
                          twsr_pkg::OutBits'(got.done_res));
          if (got.sample_word !== want.sample_word)
            note_mismatch("sample_word", want.sample_word, got.sample_word);
        end
      end
    end
  end

  task automatic queue_tick(input logic start, input logic din);
    tick_q.push_back({din, start});
    ticks_queued++;
  endtask

  task automatic wait_drained();
    while (ticks_sent != ticks_queued || predicted_beats_q.size() != 0)
      @(posedge clk_i);
  endtask

  // Feed idle ticks until the read in progress is over; pat: 0 random, 1 ones, 2 zeros
  task automatic settle_reader(input int pat);
    wait_drained();
    while (rd_phase != RD_IDLE) begin
      repeat (SettleChunk) begin
        queue_tick(1'b0, (pat == 0) ? 1'($urandom_range(1)) : (pat == 1));
      end
      wait_drained();
    end
  endtask

  task automatic write_reg(input logic [twsr_pkg::CfgIdxW-1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= twsr_pkg::CfgDataW'(val);
  endtask

  // Only called with the reader idle and nothing in flight
  task automatic apply_settings(input int unsigned bc, input int unsigned ep,
                                input int unsigned hp, input logic icl, input logic rl);
    cfg.bit_count = 6'(bc);
    cfg.extra_pulses = 4'(ep);
    cfg.half_period = 16'(hp);
    cfg.idle_clock_level = icl;
    cfg.ready_level = rl;
    write_reg(twsr_pkg::CfgBitCount, bc);
    write_reg(twsr_pkg::CfgExtraPulses, ep);
    write_reg(twsr_pkg::CfgHalfPeriod, hp);
    write_reg(twsr_pkg::CfgIdleClock, 32'(icl));
    write_reg(twsr_pkg::CfgReadyLevel, 32'(rl));
    @(negedge clk_i) cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned n;
    int unsigned rand_ticks;
    int unsigned phase_no;
    int unsigned bc, ep, hp;
    bit          held_b, held_c;

    cfg = '{bit_count: 6'd24, extra_pulses: 4'd1, half_period: 16'd1,
            idle_clock_level: 1'b0, ready_level: 1'b0};
    rd_phase = RD_IDLE;
    rd_shift = '0;
    rd_bits = 0;
    rd_pulses = 0;
    rd_ticks = 0;
    rd_clk = 1'b0;
    rand_ticks = 0;
    phase_no = 0;
    held_b = 1'b0;
    held_c = 1'b0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // One read with the register values from reset
    queue_tick(1'b1, 1'b1);
    queue_tick(1'b0, 1'b0);
    settle_reader(0);

    // No data bits, no extra pulses, zero half period: done right at ready.
    // Start tick ignores din even when it matches ready; start while waiting is dropped.
    apply_settings(0, 0, 0, 1'b1, 1'b1);
    queue_tick(1'b1, 1'b1);
    queue_tick(1'b1, 1'b0);
    queue_tick(1'b0, 1'b1);
    queue_tick(1'b0, 1'b0);
    settle_reader(0);

    // Single zero bit followed by the most extra pulses; start while clocking dropped
    apply_settings(1, 15, 1, 1'b0, 1'b0);
    queue_tick(1'b1, 1'b1);
    queue_tick(1'b0, 1'b0);
    queue_tick(1'b1, 1'b0);
    queue_tick(1'b1, 1'b0);
    settle_reader(2);

    // Full word of ones
    apply_settings(32, 0, 2, 1'b1, 1'b1);
    queue_tick(1'b1, 1'b0);
    queue_tick(1'b0, 1'b1);
    settle_reader(1);

    // More bits than the word holds: older bits fall off
    apply_settings(63, 2, 1, 1'b0, 1'b1);
    queue_tick(1'b1, 1'b0);
    queue_tick(1'b0, 1'b1);
    settle_reader(0);

    // Long half period
    apply_settings(1, 0, 40, 1'b1, 1'b0);
    queue_tick(1'b1, 1'b1);
    queue_tick(1'b0, 1'b0);
    settle_reader(0);

    while (rand_ticks < 400) begin
      if (rand_ticks < 135) begin
        send_idle_pct = 18;
        recv_idle_pct = 82;
      end else if (rand_ticks < 270) begin
        send_idle_pct = 82;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      bc = ($urandom_range(9) < 8) ? $urandom_range(10) : $urandom_range(63);
      ep = ($urandom_range(9) < 7) ? $urandom_range(3) : $urandom_range(15);
      hp = ($urandom_range(9) < 7) ? $urandom_range(2) : $urandom_range(3, 6);
      apply_settings(bc, ep, hp, 1'($urandom_range(1)), 1'($urandom_range(1)));

      // Long output stall while the sender keeps offering ticks
      if ((rand_ticks >= 135 && rand_ticks < 270 && !held_b) ||
          (rand_ticks >= 270 && !held_c)) begin
        if (rand_ticks >= 270) held_c = 1'b1;
        else held_b = 1'b1;
        hold_requests++;
      end

      n = $urandom_range(30, 90);
      for (int unsigned i = 0; i < n; i++) begin
        queue_tick(($urandom_range(99) < 20), 1'($urandom_range(1)));
        // sender pause until every result is back
        if (i == n / 2 && phase_no % 3 == 1) wait_drained();
      end
      rand_ticks += n;
      phase_no++;
      settle_reader(0);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
